FILE: hw/rtl/lsv_pkg.sv
`timescale 1ns / 1ps

package lsv_pkg;

    // operation codes
    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_NOTE = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;
    localparam logic [1:0] OP_STOP = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_SOUND_LENGTH  = 2'd0;
    localparam logic [1:0] CFG_LOOP_DURATION = 2'd1;
    localparam logic [1:0] CFG_STEREO_SOURCE = 2'd2;
    localparam logic [1:0] CFG_MONO_OUTPUT   = 2'd3;

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;

    localparam logic [15:0] SOUND_LENGTH_RST  = 16'd65534;
    localparam logic [15:0] LOOP_DURATION_RST = 16'd65535;
    localparam logic        STEREO_SOURCE_RST = 1'b1;
    localparam logic        MONO_OUTPUT_RST   = 1'b0;

    // controller to datapath commands, at most one high per cycle
    typedef struct packed {
        logic capture;
        logic rd0;
        logic rd1;
        logic interp;
        logic scale;
        logic finish;
    } t_dp_cmd;

endpackage

FILE: hw/rtl/lsv_ctrl.sv
`timescale 1ns / 1ps

module lsv_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic [1:0]         i_operation,
    input  logic               i_out_ready,
    input  logic               i_active,
    output logic               o_in_ready,
    output logic               o_out_valid,
    output lsv_pkg::t_dp_cmd   o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD0,
        S_RD1,
        S_INTERP,
        S_SCALE,
        S_FIN
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   in_fire;
    logic   out_free;

    assign in_fire  = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    o_cmd.capture = 1'b1;
                    if (i_operation == lsv_pkg::OP_TICK && i_active) begin
                        n_state = S_RD0;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_RD0: begin
                o_cmd.rd0 = 1'b1;
                n_state   = S_RD1;
            end
            S_RD1: begin
                o_cmd.rd1 = 1'b1;
                n_state   = S_INTERP;
            end
            S_INTERP: begin
                o_cmd.interp = 1'b1;
                n_state      = S_SCALE;
            end
            S_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = S_FIN;
            end
            S_FIN: begin
                // hold the result until the output register frees up
                if (out_free) begin
                    o_cmd.finish = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    a_finish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> (!r_out_valid || i_out_ready))
        else $error("result written over a pending word");

    a_tick_starts_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_operation == lsv_pkg::OP_TICK && i_active) |=> (r_state == S_RD0))
        else $error("active tick did not start the memory reads");

    a_other_skips_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && !(i_operation == lsv_pkg::OP_TICK && i_active)) |=> (r_state == S_FIN))
        else $error("non-playing word did not go straight to finish");

    a_finish_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> (r_out_valid && r_state == S_IDLE))
        else $error("finish did not present a result");

endmodule

FILE: hw/rtl/lsv_datapath.sv
`timescale 1ns / 1ps

module lsv_datapath #(
    parameter int MEMORY_DEPTH = 65536,
    parameter int SAMPLE_BITS  = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  lsv_pkg::t_dp_cmd                      i_cmd,
    input  logic                                  i_cfg_valid,
    input  logic [lsv_pkg::CFG_INDEX_BITS-1:0]    i_cfg_index,
    input  logic [lsv_pkg::CFG_DATA_BITS-1:0]     i_cfg_data,
    input  logic [1:0]                            i_operation,
    input  logic [15:0]                           i_load_address,
    input  logic signed [SAMPLE_BITS-1:0]         i_load_left,
    input  logic signed [SAMPLE_BITS-1:0]         i_load_right,
    input  logic [31:0]                           i_start_position,
    input  logic [23:0]                           i_pitch_step,
    input  logic [15:0]                           i_note_gain,
    input  logic [15:0]                           i_envelope,
    input  logic                                  i_key_down,
    output logic                                  o_active,
    output logic signed [SAMPLE_BITS-1:0]         o_out_left,
    output logic signed [SAMPLE_BITS-1:0]         o_out_right,
    output logic                                  o_voice_active
);

    localparam int SB = SAMPLE_BITS;
    localparam int AW = $clog2(MEMORY_DEPTH);
    localparam int VW = SB + 18;   // interpolation sum
    localparam int PW = SB + 34;   // sample times gain product

    // voice state and configuration
    logic [31:0] r_pos;
    logic [31:0] r_loop_start;
    logic [32:0] r_count;
    logic [23:0] r_step;
    logic [15:0] r_gain;
    logic        r_active;
    logic [15:0] r_len;
    logic [15:0] r_dur;
    logic        r_stereo;
    logic        r_mono;

    // sample memories
    logic signed [SB-1:0] r_mem_left  [0:MEMORY_DEPTH-1];
    logic signed [SB-1:0] r_mem_right [0:MEMORY_DEPTH-1];

    // per-tick working registers
    logic                 r_is_tick;
    logic                 r_key;
    logic [31:0]          r_g;
    logic signed [SB-1:0] r_a_left, r_a_right, r_b_left, r_b_right;
    logic signed [SB:0]   r_s_left, r_s_right;
    logic [32:0]          r_pos_sum;
    logic [32:0]          r_cnt_sum;
    logic signed [PW-1:0] r_p_left, r_p_right;
    logic signed [SB-1:0] r_out_left, r_out_right;
    logic                 r_out_active;

    logic [AW-1:0] wr_addr, rd_addr0, rd_addr1;
    logic [16:0]   next_index;

    assign wr_addr    = AW'(i_load_address);
    assign rd_addr0   = AW'(r_pos[31:16]);
    assign next_index = {1'b0, r_pos[31:16]} + 17'd1;
    assign rd_addr1   = AW'(next_index);

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture && i_operation == lsv_pkg::OP_LOAD) begin
            r_mem_left[wr_addr] <= i_load_left;
        end
        if (i_cmd.rd0) begin
            r_a_left <= r_mem_left[rd_addr0];
        end
        if (i_cmd.rd1) begin
            r_b_left <= r_mem_left[rd_addr1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture && i_operation == lsv_pkg::OP_LOAD) begin
            r_mem_right[wr_addr] <= i_load_right;
        end
        if (i_cmd.rd0) begin
            r_a_right <= r_mem_right[rd_addr0];
        end
        if (i_cmd.rd1) begin
            r_b_right <= r_mem_right[rd_addr1];
        end
    end

    // linear interpolation: a*2^16 + (b-a)*f, rounded half away from zero
    logic signed [SB:0]   diff_left, diff_right;
    logic signed [VW-1:0] v_left, v_right, rv_left, rv_right;
    logic signed [SB:0]   s_right_src;

    always_comb begin
        diff_left  = r_b_left - r_a_left;
        diff_right = r_b_right - r_a_right;
        v_left  = $signed({{2{r_a_left[SB-1]}}, r_a_left, 16'b0})
                + diff_left * $signed({1'b0, r_pos[15:0]});
        v_right = $signed({{2{r_a_right[SB-1]}}, r_a_right, 16'b0})
                + diff_right * $signed({1'b0, r_pos[15:0]});
        rv_left  = v_left + VW'(32768) - VW'(v_left[VW-1]);
        rv_right = v_right + VW'(32768) - VW'(v_right[VW-1]);
        s_right_src = r_stereo ? rv_right[SB+16:16] : rv_left[SB+16:16];
    end

    // output rounding and saturation
    function automatic logic [SB-1:0] sat_q(input logic [SB+1:0] q);
        logic [2:0] top;
        top = q[SB+1:SB-1];
        if ((&top) || !(|top)) begin
            return q[SB-1:0];
        end else if (q[SB+1]) begin
            return {1'b1, {(SB-1){1'b0}}};
        end else begin
            return {1'b0, {(SB-1){1'b1}}};
        end
    endfunction

    logic signed [PW-1:0] x_left, x_right;
    logic signed [PW:0]   m_sum, x_mono;
    logic [SB-1:0]        y_left, y_right;
    logic [32:0]          len_q;
    logic [32:0]          pos_wrap;
    logic                 loop_hit;

    always_comb begin
        x_left  = r_p_left + PW'(64'd1 << 31) - PW'(r_p_left[PW-1]);
        x_right = r_p_right + PW'(64'd1 << 31) - PW'(r_p_right[PW-1]);
        m_sum   = {r_p_left[PW-1], r_p_left} + {r_p_right[PW-1], r_p_right};
        x_mono  = m_sum + (PW+1)'(64'd1 << 32) - (PW+1)'(m_sum[PW]);
        if (r_mono) begin
            y_left  = sat_q(x_mono[PW:33]);
            y_right = '0;
        end else begin
            y_left  = sat_q(x_left[PW-1:32]);
            y_right = sat_q(x_right[PW-1:32]);
        end

        len_q    = {1'b0, r_len, 16'b0};
        pos_wrap = (r_pos_sum >= len_q) ? (r_pos_sum - len_q) : r_pos_sum;
        loop_hit = r_cnt_sum > {1'b0, r_dur, 16'b0};
    end

    // working registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_is_tick <= (i_operation == lsv_pkg::OP_TICK) && r_active;
            r_key     <= i_key_down;
            r_g       <= r_gain * i_envelope;
        end
        if (i_cmd.interp) begin
            r_s_left  <= rv_left[SB+16:16];
            r_s_right <= s_right_src;
            r_pos_sum <= {1'b0, r_pos} + 33'(r_step);
            r_cnt_sum <= r_count + 33'(r_step);
        end
        if (i_cmd.scale) begin
            r_p_left  <= r_s_left * $signed({1'b0, r_g});
            r_p_right <= r_s_right * $signed({1'b0, r_g});
        end
        if (i_cmd.finish) begin
            if (r_is_tick) begin
                r_out_left   <= y_left;
                r_out_right  <= y_right;
                r_out_active <= r_key;
            end else begin
                r_out_left   <= '0;
                r_out_right  <= '0;
                r_out_active <= r_active;
            end
        end
    end

    // voice state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_loop_start <= '0;
            r_count      <= '0;
            r_step       <= '0;
            r_gain       <= '0;
            r_active     <= 1'b0;
            r_len        <= lsv_pkg::SOUND_LENGTH_RST;
            r_dur        <= lsv_pkg::LOOP_DURATION_RST;
            r_stereo     <= lsv_pkg::STEREO_SOURCE_RST;
            r_mono       <= lsv_pkg::MONO_OUTPUT_RST;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    lsv_pkg::CFG_SOUND_LENGTH:  r_len    <= i_cfg_data;
                    lsv_pkg::CFG_LOOP_DURATION: r_dur    <= i_cfg_data;
                    lsv_pkg::CFG_STEREO_SOURCE: r_stereo <= i_cfg_data[0];
                    lsv_pkg::CFG_MONO_OUTPUT:   r_mono   <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_cmd.capture) begin
                case (i_operation)
                    lsv_pkg::OP_NOTE: begin
                        r_pos        <= i_start_position;
                        r_loop_start <= i_start_position;
                        r_step       <= i_pitch_step;
                        r_gain       <= i_note_gain;
                        r_count      <= '0;
                        r_active     <= 1'b1;
                    end
                    lsv_pkg::OP_STOP: begin
                        r_active <= 1'b0;
                    end
                    default: ;
                endcase
            end
            if (i_cmd.finish && r_is_tick) begin
                // key release wins over the loop jump
                if (!r_key) begin
                    r_active <= 1'b0;
                    r_pos    <= pos_wrap[31:0];
                    r_count  <= r_cnt_sum;
                end else if (loop_hit) begin
                    r_pos    <= r_loop_start;
                    r_count  <= '0;
                end else begin
                    r_pos    <= pos_wrap[31:0];
                    r_count  <= r_cnt_sum;
                end
            end
        end
    end

    assign o_active       = r_active;
    assign o_out_left     = r_out_left;
    assign o_out_right    = r_out_right;
    assign o_voice_active = r_out_active;

    a_stop_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.capture && i_operation == lsv_pkg::OP_STOP) |=> !r_active)
        else $error("hard stop left the voice active");

    a_note_sets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.capture && i_operation == lsv_pkg::OP_NOTE) |=> (r_active && r_count == '0))
        else $error("note on did not start the voice");

    a_release_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.finish && r_is_tick && !r_key) |=> (!r_active && !r_out_active))
        else $error("key release did not stop the voice");

    a_pos_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.rd0 || i_cmd.rd1 || i_cmd.interp) |=> $stable(r_pos))
        else $error("position moved during the sample reads");

endmodule

FILE: hw/rtl/looping_sample_voice.sv
`timescale 1ns / 1ps
// An active tick is accepted, then reads the one-port sample memory twice,
// then interpolates, scales and rounds; every other word goes straight to its result.
// A result waits while the output register still holds an unread one, and no new
// word is accepted until the last one has finished.
// Reset (i_rst_n synchronous, active low) idles the voice, clears position,
// count, step and gain, and loads configuration defaults; sample memory is not cleared.

module looping_sample_voice #(
    parameter int MEMORY_DEPTH = 65536,
    parameter int SAMPLE_BITS  = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [1:0]                            i_operation,
    input  logic [15:0]                           i_load_address,
    input  logic signed [SAMPLE_BITS-1:0]         i_load_left,
    input  logic signed [SAMPLE_BITS-1:0]         i_load_right,
    input  logic [31:0]                           i_start_position,
    input  logic [23:0]                           i_pitch_step,
    input  logic [15:0]                           i_note_gain,
    input  logic [15:0]                           i_envelope,
    input  logic                                  i_key_down,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [SAMPLE_BITS-1:0]         o_out_left,
    output logic signed [SAMPLE_BITS-1:0]         o_out_right,
    output logic                                  o_voice_active,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [lsv_pkg::CFG_INDEX_BITS-1:0]    i_cfg_index,
    input  logic [lsv_pkg::CFG_DATA_BITS-1:0]     i_cfg_data
);

    lsv_pkg::t_dp_cmd cmd;
    logic             active;

    assign o_cfg_ready = 1'b1;

    lsv_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_operation (i_operation),
        .i_out_ready (i_out_ready),
        .i_active    (active),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    lsv_datapath #(
        .MEMORY_DEPTH (MEMORY_DEPTH),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_operation      (i_operation),
        .i_load_address   (i_load_address),
        .i_load_left      (i_load_left),
        .i_load_right     (i_load_right),
        .i_start_position (i_start_position),
        .i_pitch_step     (i_pitch_step),
        .i_note_gain      (i_note_gain),
        .i_envelope       (i_envelope),
        .i_key_down       (i_key_down),
        .o_active         (active),
        .o_out_left       (o_out_left),
        .o_out_right      (o_out_right),
        .o_voice_active   (o_voice_active)
    );

endmodule

FILE: bench/tb_looping_sample_voice.sv
`timescale 1ns / 1ps

module tb_looping_sample_voice;

    localparam int MEMORY_DEPTH = 65536;
    localparam int SAMPLE_BITS  = 16;
    localparam int CYCLE_LIMIT  = 2000000;
    localparam int PLAY_ITEMS   = 105;     // per phase, eight phases
    localparam int FILL_DEPTH   = 512;     // entries that random notes can reach
    localparam logic [31:0] STEP_MAX = 32'h0008_0000;
    localparam longint SAMPLE_MAX = (64'sd1 <<< (SAMPLE_BITS - 1)) - 1;
    localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;

    typedef struct packed {
        logic [1:0]         op;
        logic [15:0]        addr;
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic [31:0]        start;
        logic [23:0]        step;
        logic [15:0]        gain;
        logic [15:0]        env;
        logic               key;
    } t_voice_word;

    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic               active;
    } t_voice_result;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               i_in_valid = 1'b0;
    logic                               o_in_ready;
    logic [1:0]                         i_operation = lsv_pkg::OP_LOAD;
    logic [15:0]                        i_load_address = '0;
    logic signed [15:0]                 i_load_left = '0;
    logic signed [15:0]                 i_load_right = '0;
    logic [31:0]                        i_start_position = '0;
    logic [23:0]                        i_pitch_step = '0;
    logic [15:0]                        i_note_gain = '0;
    logic [15:0]                        i_envelope = '0;
    logic                               i_key_down = 1'b0;
    logic                               o_out_valid;
    logic                               i_out_ready = 1'b0;
    logic signed [15:0]                 o_out_left;
    logic signed [15:0]                 o_out_right;
    logic                               o_voice_active;
    logic                               i_cfg_valid = 1'b0;
    logic                               o_cfg_ready;
    logic [lsv_pkg::CFG_INDEX_BITS-1:0] i_cfg_index = lsv_pkg::CFG_SOUND_LENGTH;
    logic [lsv_pkg::CFG_DATA_BITS-1:0]  i_cfg_data = '0;

    looping_sample_voice #(
        .MEMORY_DEPTH(MEMORY_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_operation     (i_operation),
        .i_load_address  (i_load_address),
        .i_load_left     (i_load_left),
        .i_load_right    (i_load_right),
        .i_start_position(i_start_position),
        .i_pitch_step    (i_pitch_step),
        .i_note_gain     (i_note_gain),
        .i_envelope      (i_envelope),
        .i_key_down      (i_key_down),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out_left      (o_out_left),
        .o_out_right     (o_out_right),
        .o_voice_active  (o_voice_active),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // voice model state
    logic signed [15:0] left_samples [MEMORY_DEPTH];
    logic signed [15:0] right_samples [MEMORY_DEPTH];
    logic [31:0] play_pos;
    logic [31:0] loop_pos;
    logic [32:0] played;
    logic [23:0] step_q;
    logic [15:0] gain_q;
    logic        voice_on;
    logic [15:0] play_len;
    logic [15:0] loop_len;
    logic        use_right;
    logic        mix_mono;

    t_voice_word   pending_words[$];
    t_voice_result expected_samples[$];
    logic          word_taken = 1'b0;
    int            sender_idle_pct = 0;
    int            sink_stall_pct = 0;
    int            mismatch_count = 0;
    int            cycle_count = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint round_half_away(longint v, int sh);
        longint half;
        half = 64'sd1 <<< (sh - 1);
        if (v < 0)
            return -((-v + half) >>> sh);
        return (v + half) >>> sh;
    endfunction

    function automatic logic signed [15:0] clamp_sample(longint v);
        if (v > SAMPLE_MAX)
            return SAMPLE_MAX[15:0];
        if (v < SAMPLE_MIN)
            return SAMPLE_MIN[15:0];
        return v[15:0];
    endfunction

    function automatic longint blend(longint a, longint b, logic [15:0] f);
        return round_half_away(a * (64'sd65536 - longint'(f)) + b * longint'(f), 16);
    endfunction

    task automatic predict_voice(input t_voice_word w, output t_voice_result r);
        logic [15:0] p0;
        logic [15:0] p1;
        longint      sl;
        longint      sr;
        longint      g;
        longint      pl;
        longint      pr;
        logic [32:0] nxt;
        logic [32:0] wrap_at;
        r = '0;
        case (w.op)
            lsv_pkg::OP_LOAD: begin
                left_samples[w.addr] = w.left;
                right_samples[w.addr] = w.right;
            end
            lsv_pkg::OP_NOTE: begin
                play_pos = w.start;
                loop_pos = w.start;
                step_q = w.step;
                gain_q = w.gain;
                played = '0;
                voice_on = 1'b1;
            end
            lsv_pkg::OP_STOP: voice_on = 1'b0;
            lsv_pkg::OP_TICK: begin
                if (voice_on) begin
                    p0 = play_pos[31:16];
                    p1 = p0 + 16'd1;
                    sl = blend(longint'(left_samples[p0]), longint'(left_samples[p1]),
                               play_pos[15:0]);
                    sr = use_right ? blend(longint'(right_samples[p0]),
                                           longint'(right_samples[p1]), play_pos[15:0])
                                   : sl;
                    g = longint'(gain_q) * longint'(w.env);
                    pl = sl * g;
                    pr = sr * g;
                    if (mix_mono) begin
                        r.left = clamp_sample(round_half_away(pl + pr, 33));
                    end else begin
                        r.left = clamp_sample(round_half_away(pl, 32));
                        r.right = clamp_sample(round_half_away(pr, 32));
                    end
                    nxt = {1'b0, play_pos} + 33'(step_q);
                    wrap_at = {1'b0, play_len, 16'h0000};
                    if (nxt >= wrap_at)
                        nxt = nxt - wrap_at;
                    play_pos = nxt[31:0];
                    played = played + 33'(step_q);
                    // release wins over the loop jump
                    if (!w.key) begin
                        voice_on = 1'b0;
                    end else if (played > {1'b0, loop_len, 16'h0000}) begin
                        played = '0;
                        play_pos = loop_pos;
                    end
                end
            end
            default: ;
        endcase
        r.active = voice_on;
    endtask

    task automatic report_mismatch(input string what, input longint want, input longint got);
        mismatch_count++;
        $display("ERROR @%0t: %s expected %0d got %0d", $time, what, want, got);
    endtask

    // input side: hold valid until taken, idle at random between words
    always @(negedge i_clk) begin : drive_words
        t_voice_word w;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_out_ready <= 1'b0;
        end else begin
            if (!i_in_valid || word_taken) begin
                if (pending_words.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
                    w = pending_words.pop_front();
                    i_in_valid <= 1'b1;
                    i_operation <= w.op;
                    i_load_address <= w.addr;
                    i_load_left <= w.left;
                    i_load_right <= w.right;
                    i_start_position <= w.start;
                    i_pitch_step <= w.step;
                    i_note_gain <= w.gain;
                    i_envelope <= w.env;
                    i_key_down <= w.key;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            i_out_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge i_clk) begin : watch_words
        t_voice_word   w;
        t_voice_result want;
        word_taken <= i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    lsv_pkg::CFG_SOUND_LENGTH:  play_len = i_cfg_data[15:0];
                    lsv_pkg::CFG_LOOP_DURATION: loop_len = i_cfg_data[15:0];
                    lsv_pkg::CFG_STEREO_SOURCE: use_right = i_cfg_data[0];
                    lsv_pkg::CFG_MONO_OUTPUT:   mix_mono = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (o_out_valid && i_out_ready) begin
                if (expected_samples.size() == 0) begin
                    report_mismatch("unexpected word, left", 64'sd0, longint'(o_out_left));
                end else begin
                    want = expected_samples.pop_front();
                    if (o_out_left !== want.left)
                        report_mismatch("out_left", longint'(want.left),
                                        longint'(o_out_left));
                    if (o_out_right !== want.right)
                        report_mismatch("out_right", longint'(want.right),
                                        longint'(o_out_right));
                    if (o_voice_active !== want.active)
                        report_mismatch("voice_active", longint'(want.active),
                                        longint'(o_voice_active));
                end
            end
            if (i_in_valid && o_in_ready) begin
                w = '{i_operation, i_load_address, i_load_left, i_load_right,
                      i_start_position, i_pitch_step, i_note_gain, i_envelope, i_key_down};
                predict_voice(w, want);
                expected_samples.push_back(want);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // every field random, so unused fields toggle too
    function automatic t_voice_word random_word(logic [1:0] op);
        t_voice_word w;
        w.op = op;
        w.addr = 16'($urandom);
        w.left = 16'($urandom);
        w.right = 16'($urandom);
        w.start = $urandom;
        w.step = 24'($urandom);
        w.gain = 16'($urandom);
        w.env = 16'($urandom);
        w.key = 1'($urandom);
        return w;
    endfunction

    function automatic t_voice_word make_load(logic [15:0] a, logic [15:0] l, logic [15:0] r);
        t_voice_word w;
        w = random_word(lsv_pkg::OP_LOAD);
        w.addr = a;
        w.left = l;
        w.right = r;
        return w;
    endfunction

    function automatic t_voice_word make_note(logic [31:0] s, logic [23:0] st,
                                              logic [15:0] g);
        t_voice_word w;
        w = random_word(lsv_pkg::OP_NOTE);
        w.start = s;
        w.step = st;
        w.gain = g;
        return w;
    endfunction

    function automatic t_voice_word make_tick(logic [15:0] e, logic k);
        t_voice_word w;
        w = random_word(lsv_pkg::OP_TICK);
        w.env = e;
        w.key = k;
        return w;
    endfunction

    // start below 256 samples and step below the length and at most 8 samples,
    // so a run of ticks stays inside the filled entries
    function automatic t_voice_word random_note();
        logic [31:0] s;
        logic [23:0] st;
        logic [15:0] g;
        logic [15:0] reach;
        logic [31:0] step_cap;
        logic [31:0] cap;
        int          pick;
        reach = (play_len < 16'd256) ? play_len : 16'd256;
        if ($urandom_range(99) < 60)
            s = $urandom_range({reach, 16'h0000} - 32'd1, 0);
        else
            s = $urandom_range(32'h00FF_FFFF, 0);
        step_cap = {play_len, 16'h0000} - 32'd1;
        if (step_cap > STEP_MAX)
            step_cap = STEP_MAX;
        pick = $urandom_range(99);
        if (pick < 50)
            cap = (step_cap < 32'h20000) ? step_cap : 32'h20000;
        else if (pick < 80)
            cap = (step_cap < 32'hFFFF) ? step_cap : 32'hFFFF;
        else
            cap = step_cap;
        st = 24'($urandom_range(cap, 1));
        g = ($urandom_range(4) == 0) ? 16'hFFFF : 16'($urandom);
        return make_note(s, st, g);
    endfunction

    function automatic logic [15:0] random_sample();
        case ($urandom_range(15))
            0: return 16'h7FFF;
            1: return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic write_register(input logic [lsv_pkg::CFG_INDEX_BITS-1:0] idx,
                                  input logic [lsv_pkg::CFG_DATA_BITS-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic apply_settings(input logic [15:0] len, input logic [15:0] loop_d,
                                  input logic stereo, input logic mono);
        write_register(lsv_pkg::CFG_SOUND_LENGTH, len);
        write_register(lsv_pkg::CFG_LOOP_DURATION, loop_d);
        // one-bit registers get junk above bit 0
        write_register(lsv_pkg::CFG_STEREO_SOURCE, {15'($urandom), stereo});
        write_register(lsv_pkg::CFG_MONO_OUTPUT, {15'($urandom), mono});
    endtask

    task automatic wait_idle();
        while (pending_words.size() != 0 || i_in_valid || expected_samples.size() != 0)
            @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic queue_play_phase(input int target);
        int          queued;
        int          pick;
        int          n;
        t_voice_word w;
        queued = 0;
        while (queued < target) begin
            pick = $urandom_range(99);
            if (pick < 65) begin
                // note, then a run of ticks, maybe released at the end
                pending_words.push_back(random_note());
                n = $urandom_range(24, 2);
                for (int k = 0; k < n; k++) begin
                    if ($urandom_range(19) == 0)
                        pending_words.push_back(
                            make_load(16'($urandom), random_sample(), random_sample()));
                    w = make_tick(16'($urandom), 1'b1);
                    if (k == n - 1)
                        w.key = ($urandom_range(2) == 0);
                    else if ($urandom_range(9) == 0)
                        w.env = ($urandom_range(1) == 0) ? 16'h0000 : 16'hFFFF;
                    pending_words.push_back(w);
                end
                queued += n + 1;
            end else if (pick < 80) begin
                n = $urandom_range(4, 1);
                repeat (n)
                    pending_words.push_back(
                        make_load(16'($urandom), random_sample(), random_sample()));
                queued += n;
            end else if (pick < 88) begin
                pending_words.push_back(random_word(lsv_pkg::OP_STOP));
                pending_words.push_back(make_tick(16'($urandom), 1'($urandom)));
                queued += 1;
            end else begin
                pending_words.push_back(random_note());
                queued += 1;
            end
        end
    endtask

    initial begin
        play_pos = '0;
        loop_pos = '0;
        played = '0;
        step_q = '0;
        gain_q = '0;
        voice_on = 1'b0;
        play_len = lsv_pkg::SOUND_LENGTH_RST;
        loop_len = lsv_pkg::LOOP_DURATION_RST;
        use_right = lsv_pkg::STEREO_SOURCE_RST;
        mix_mono = lsv_pkg::MONO_OUTPUT_RST;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // write the low entries that notes can reach before any tick reads them
        for (int a = 0; a < FILL_DEPTH; a++)
            pending_words.push_back(make_load(a[15:0], random_sample(), random_sample()));
        wait_idle();

        // directed words, short loop so the jump back shows up quickly
        apply_settings(16'd65534, 16'd2, 1'b1, 1'b0);
        pending_words.push_back(make_tick(16'hFFFF, 1'b1));     // tick while idle
        pending_words.push_back(random_word(lsv_pkg::OP_STOP));
        pending_words.push_back(make_load(16'd0, 16'h7FFF, 16'h8000));
        pending_words.push_back(make_load(16'hFFFE, 16'h8000, 16'h8000));
        pending_words.push_back(make_load(16'hFFFF, 16'h8000, 16'h7FFF));
        // last entry, read wraps to entry 0, position past the length
        pending_words.push_back(make_note(32'hFFFF_8000, 24'h010000, 16'hFFFF));
        pending_words.push_back(make_tick(16'hFFFF, 1'b1));
        pending_words.push_back(make_tick(16'hFFFF, 1'b1));
        pending_words.push_back(make_tick(16'h0000, 1'b1));
        pending_words.push_back(make_note(32'h0000_0000, 24'h000000, 16'hFFFF));
        pending_words.push_back(make_tick(16'hFFFF, 1'b1));
        pending_words.push_back(make_tick(16'h8000, 1'b1));
        pending_words.push_back(make_note(32'h0001_8000, 24'hFFFFFF, 16'h0000));
        pending_words.push_back(make_tick(16'hFFFF, 1'b1));
        pending_words.push_back(make_note(32'h0001_0000, 24'h010000, 16'h8000));
        repeat (5)
            pending_words.push_back(make_tick(16'hFFFF, 1'b1));
        pending_words.push_back(make_tick(16'hFFFF, 1'b0));     // key release
        pending_words.push_back(make_tick(16'hFFFF, 1'b1));
        pending_words.push_back(make_note(32'hFFFE_FFFF, 24'h008000, 16'hFFFF));
        pending_words.push_back(make_tick(16'h1234, 1'b1));
        pending_words.push_back(random_word(lsv_pkg::OP_STOP)); // stop while playing
        pending_words.push_back(make_tick(16'hFFFF, 1'b1));
        wait_idle();

        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: apply_settings(16'd65534, 16'd65535, 1'b1, 1'b0);
                1: apply_settings(16'd1, 16'd0, 1'b0, 1'b1);
                default: apply_settings(
                    ($urandom_range(1) == 0) ? 16'($urandom_range(400, 1))
                                             : 16'($urandom_range(65534, 1)),
                    ($urandom_range(1) == 0) ? 16'($urandom_range(60, 0))
                                             : 16'($urandom),
                    1'($urandom), 1'($urandom));
            endcase
            case (ph % 4)
                0: begin sender_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin sender_idle_pct = 68; sink_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  sink_stall_pct = 68; end
                default: begin sender_idle_pct = 15; sink_stall_pct = 15; end
            endcase
            queue_play_phase(PLAY_ITEMS);
            wait_idle();
        end

        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
